FILE: rtl/slct_pkg.sv
// ----------------------------------------------------------------------------
// slct_pkg
// Widths, stage payload types and constants for the segment/line crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

package slct_pkg;

    // Coordinate format
    localparam int COORD_FRAC_BITS = 8;
    localparam int COORD_W         = 24;
    localparam int TOL_W           = 23;

    // Operand widths
    localparam int LINE_AB_W = 25;
    localparam int LINE_C_W  = 49;
    localparam int DIFF_W    = COORD_W + 1;        // a2, b2, spans, sums
    localparam int PROD_W    = 2 * COORD_W;        // x*y products
    localparam int C2_W      = PROD_W + 1;         // two-point constant term
    localparam int HALF_W    = 24;                 // low split for wide operands
    localparam int PP_W      = 50;                 // partial products
    localparam int D_W       = 51;                 // cross term
    localparam int N_W       = 75;                 // numerators, signed
    localparam int BND_W     = COORD_W + 2;        // shrunk box bounds
    localparam int SPAN_W    = DIFF_W + TOL_W;     // relative test operands
    localparam int Q_W       = COORD_W;            // quotient bits kept

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // Box test data carried alongside the arithmetic
    typedef struct packed {
        logic                    par;
        logic                    nv;
        logic                    nh;
        logic signed [BND_W-1:0] xlo;
        logic signed [BND_W-1:0] xhi;
        logic signed [BND_W-1:0] ylo;
        logic signed [BND_W-1:0] yhi;
    } t_box;

    // One divider stage
    typedef struct packed {
        t_box               box;
        logic [D_W-1:0]     dm;
        logic [N_W-1:0]     remx;
        logic [N_W-1:0]     remy;
        logic [Q_W-1:0]     qx;
        logic [Q_W-1:0]     qy;
        logic               negx;
        logic               negy;
        logic               ovfx;
        logic               ovfy;
    } t_div;

endpackage

`default_nettype wire

FILE: rtl/slct_item_if.sv
// ----------------------------------------------------------------------------
// slct_item_if
// Input channel: one line and one segment per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface slct_item_if import slct_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [LINE_AB_W-1:0] line_a;
    logic signed [LINE_AB_W-1:0] line_b;
    logic signed [LINE_C_W-1:0]  line_c;
    logic signed [COORD_W-1:0]   seg_start_x;
    logic signed [COORD_W-1:0]   seg_start_y;
    logic signed [COORD_W-1:0]   seg_end_x;
    logic signed [COORD_W-1:0]   seg_end_y;

    modport source (output valid, line_a, line_b, line_c, seg_start_x, seg_start_y,
                    seg_end_x, seg_end_y, input ready);
    modport sink   (input valid, line_a, line_b, line_c, seg_start_x, seg_start_y,
                    seg_end_x, seg_end_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/slct_result_if.sv
// ----------------------------------------------------------------------------
// slct_result_if
// Output channel: crossing flags and intersection point per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface slct_result_if import slct_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      crosses;
    logic                      is_parallel;
    logic signed [COORD_W-1:0] meet_x;
    logic signed [COORD_W-1:0] meet_y;

    modport source (output valid, crosses, is_parallel, meet_x, meet_y, input ready);
    modport sink   (input valid, crosses, is_parallel, meet_x, meet_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/slct_cfg_if.sv
// ----------------------------------------------------------------------------
// slct_cfg_if
// Configuration write channel for the tolerance register.
// ----------------------------------------------------------------------------
`default_nettype none

interface slct_cfg_if import slct_pkg::*;;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/segment_line_crossing_test_unit.sv
// ----------------------------------------------------------------------------
// segment_line_crossing_test_unit
// Line versus segment intersection with a tolerance-shrunk box test.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The pipeline takes a new item every cycle while the
// output is not stalled. Each item goes through products and sums, an overflow
// check, then a 24-stage restoring divider that resolves one quotient bit per
// stage for x and y in parallel. A stalled output freezes the whole pipeline;
// nothing is dropped. The tolerance register resets to 1. The user must write it
// only while the unit is empty; the block itself does not enforce this.
`default_nettype none

module segment_line_crossing_test_unit import slct_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    slct_item_if.sink    i_item,
    slct_cfg_if.sink     i_cfg,
    slct_result_if.source o_result
);

    logic en;
    logic [TOL_W-1:0] r_tol;

    // Tolerance register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg.valid) begin
            r_tol <= i_cfg.data;
        end
    end

    logic r_out_vld;
    assign en           = !r_out_vld || o_result.ready;
    assign i_item.ready = en;

    // ---------------- stage 1: differences, endpoint products, box extents
    logic                        r1_vld;
    logic signed [LINE_AB_W-1:0] r1_a, r1_b;
    logic signed [LINE_C_W-1:0]  r1_c;
    logic signed [DIFF_W-1:0]    r1_a2, r1_b2;
    logic signed [PROD_W-1:0]    r1_p1, r1_p2;
    logic signed [COORD_W-1:0]   r1_xmin, r1_xmax, r1_ymin, r1_ymax;
    logic [DIFF_W-1:0]           r1_spx, r1_spy, r1_smx, r1_smy;

    logic signed [COORD_W-1:0] n1_xmin, n1_xmax, n1_ymin, n1_ymax;
    logic signed [DIFF_W-1:0]  n1_sx, n1_sy;

    always_comb begin
        if (i_item.seg_start_x < i_item.seg_end_x) begin
            n1_xmin = i_item.seg_start_x;
            n1_xmax = i_item.seg_end_x;
        end else begin
            n1_xmin = i_item.seg_end_x;
            n1_xmax = i_item.seg_start_x;
        end
        if (i_item.seg_start_y < i_item.seg_end_y) begin
            n1_ymin = i_item.seg_start_y;
            n1_ymax = i_item.seg_end_y;
        end else begin
            n1_ymin = i_item.seg_end_y;
            n1_ymax = i_item.seg_start_y;
        end
        n1_sx = DIFF_W'(n1_xmax) + DIFF_W'(n1_xmin);
        n1_sy = DIFF_W'(n1_ymax) + DIFF_W'(n1_ymin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= i_item.line_a;
            r1_b    <= i_item.line_b;
            r1_c    <= i_item.line_c;
            r1_a2   <= DIFF_W'(i_item.seg_end_y) - DIFF_W'(i_item.seg_start_y);
            r1_b2   <= DIFF_W'(i_item.seg_start_x) - DIFF_W'(i_item.seg_end_x);
            r1_p1   <= PROD_W'(i_item.seg_end_x) * PROD_W'(i_item.seg_start_y);
            r1_p2   <= PROD_W'(i_item.seg_start_x) * PROD_W'(i_item.seg_end_y);
            r1_xmin <= n1_xmin;
            r1_xmax <= n1_xmax;
            r1_ymin <= n1_ymin;
            r1_ymax <= n1_ymax;
            r1_spx  <= DIFF_W'(n1_xmax) - DIFF_W'(n1_xmin);
            r1_spy  <= DIFF_W'(n1_ymax) - DIFF_W'(n1_ymin);
            r1_smx  <= n1_sx[DIFF_W-1] ? DIFF_W'(-n1_sx) : n1_sx;
            r1_smy  <= n1_sy[DIFF_W-1] ? DIFF_W'(-n1_sy) : n1_sy;
        end
    end

    // ---------------- stage 2: c2, cross products, relative test products, shrunk box bounds
    logic                        r2_vld;
    logic signed [LINE_AB_W-1:0] r2_a, r2_b;
    logic signed [LINE_C_W-1:0]  r2_c;
    logic signed [DIFF_W-1:0]    r2_a2, r2_b2;
    logic signed [C2_W-1:0]      r2_c2;
    logic signed [PP_W-1:0]      r2_ab2, r2_ba2;
    logic [SPAN_W-1:0]           r2_spx, r2_spy, r2_rx, r2_ry;
    logic signed [BND_W-1:0]     r2_xlo, r2_xhi, r2_ylo, r2_yhi;
    logic signed [BND_W-1:0]     n2_tol;

    assign n2_tol = $signed({{(BND_W-TOL_W){1'b0}}, r_tol});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_c   <= r1_c;
            r2_a2  <= r1_a2;
            r2_b2  <= r1_b2;
            r2_c2  <= C2_W'(r1_p1) - C2_W'(r1_p2);
            r2_ab2 <= PP_W'(r1_a) * PP_W'(r1_b2);
            r2_ba2 <= PP_W'(r1_b) * PP_W'(r1_a2);
            r2_spx <= SPAN_W'(r1_spx) << (COORD_FRAC_BITS + 1);
            r2_spy <= SPAN_W'(r1_spy) << (COORD_FRAC_BITS + 1);
            r2_rx  <= SPAN_W'(r1_smx) * SPAN_W'(r_tol);
            r2_ry  <= SPAN_W'(r1_smy) * SPAN_W'(r_tol);
            r2_xlo <= BND_W'(r1_xmin) + n2_tol;
            r2_xhi <= BND_W'(r1_xmax) - n2_tol;
            r2_ylo <= BND_W'(r1_ymin) + n2_tol;
            r2_yhi <= BND_W'(r1_ymax) - n2_tol;
        end
    end

    // ---------------- stage 3: cross term, split partial products
    logic                   r3_vld;
    logic signed [D_W-1:0]  r3_d;
    logic signed [PP_W-1:0] r3_bc2h, r3_bc2l, r3_b2ch, r3_b2cl;
    logic signed [PP_W-1:0] r3_a2ch, r3_a2cl, r3_ac2h, r3_ac2l;
    t_box                   r3_box;

    logic signed [LINE_AB_W-1:0] n3_c2h, n3_c2l, n3_ch, n3_cl;

    assign n3_c2h = r2_c2[C2_W-1:HALF_W];
    assign n3_c2l = $signed({1'b0, r2_c2[HALF_W-1:0]});
    assign n3_ch  = r2_c[LINE_C_W-1:HALF_W];
    assign n3_cl  = $signed({1'b0, r2_c[HALF_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d       <= D_W'(r2_ab2) - D_W'(r2_ba2);
            r3_bc2h    <= PP_W'(r2_b)  * PP_W'(n3_c2h);
            r3_bc2l    <= PP_W'(r2_b)  * PP_W'(n3_c2l);
            r3_b2ch    <= PP_W'(r2_b2) * PP_W'(n3_ch);
            r3_b2cl    <= PP_W'(r2_b2) * PP_W'(n3_cl);
            r3_a2ch    <= PP_W'(r2_a2) * PP_W'(n3_ch);
            r3_a2cl    <= PP_W'(r2_a2) * PP_W'(n3_cl);
            r3_ac2h    <= PP_W'(r2_a)  * PP_W'(n3_c2h);
            r3_ac2l    <= PP_W'(r2_a)  * PP_W'(n3_c2l);
            r3_box.par <= 1'b0;
            r3_box.nv  <= r2_spx < r2_rx;
            r3_box.nh  <= r2_spy < r2_ry;
            r3_box.xlo <= r2_xlo;
            r3_box.xhi <= r2_xhi;
            r3_box.ylo <= r2_ylo;
            r3_box.yhi <= r2_yhi;
        end
    end

    // ---------------- stage 4: assemble full products, divisor magnitude
    logic                  r4_vld;
    logic signed [N_W-1:0] r4_bc2, r4_cb2, r4_ca2, r4_ac2;
    logic [D_W-1:0]        r4_dm;
    logic                  r4_dneg;
    t_box                  r4_box;
    t_box                  n4_box;

    // Flag a zero cross term on the box data
    always_comb begin
        n4_box     = r3_box;
        n4_box.par = (r3_d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_bc2     <= (N_W'(r3_bc2h) <<< HALF_W) + N_W'(r3_bc2l);
            r4_cb2     <= (N_W'(r3_b2ch) <<< HALF_W) + N_W'(r3_b2cl);
            r4_ca2     <= (N_W'(r3_a2ch) <<< HALF_W) + N_W'(r3_a2cl);
            r4_ac2     <= (N_W'(r3_ac2h) <<< HALF_W) + N_W'(r3_ac2l);
            r4_dm      <= r3_d[D_W-1] ? D_W'(-r3_d) : D_W'(r3_d);
            r4_dneg    <= r3_d[D_W-1];
            r4_box     <= n4_box;
        end
    end

    // ---------------- stage 5: numerators
    logic                  r5_vld;
    logic signed [N_W-1:0] r5_nx, r5_ny;
    logic [D_W-1:0]        r5_dm;
    logic                  r5_dneg;
    t_box                  r5_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_nx   <= r4_bc2 - r4_cb2;
            r5_ny   <= r4_ca2 - r4_ac2;
            r5_dm   <= r4_dm;
            r5_dneg <= r4_dneg;
            r5_box  <= r4_box;
        end
    end

    // ---------------- stage 6: numerator magnitudes and quotient signs
    logic           r6_vld;
    logic [N_W-1:0] r6_mx, r6_my;
    logic           r6_negx, r6_negy;
    logic [D_W-1:0] r6_dm;
    t_box           r6_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_mx   <= r5_nx[N_W-1] ? N_W'(-r5_nx) : N_W'(r5_nx);
            r6_my   <= r5_ny[N_W-1] ? N_W'(-r5_ny) : N_W'(r5_ny);
            r6_negx <= r5_nx[N_W-1] ^ r5_dneg;
            r6_negy <= r5_ny[N_W-1] ^ r5_dneg;
            r6_dm   <= r5_dm;
            r6_box  <= r5_box;
        end
    end

    // ---------------- stage 7: overflow check, divider entry
    t_div r_dv   [0:Q_W];
    logic r_dvld [0:Q_W];

    logic [N_W-1:0] n7_dtop;
    assign n7_dtop = {r6_dm, {Q_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else if (en) begin
            r_dvld[0] <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].box  <= r6_box;
            r_dv[0].dm   <= r6_dm;
            r_dv[0].remx <= r6_mx;
            r_dv[0].remy <= r6_my;
            r_dv[0].qx   <= '0;
            r_dv[0].qy   <= '0;
            r_dv[0].negx <= r6_negx;
            r_dv[0].negy <= r6_negy;
            r_dv[0].ovfx <= r6_mx >= n7_dtop;
            r_dv[0].ovfy <= r6_my >= n7_dtop;
        end
    end

    // ---------------- divider: one quotient bit per stage, MSB first
    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam int SH = Q_W - 1 - k;
        logic [N_W-1:0] dsh;
        t_div           n_d;

        assign dsh = N_W'(r_dv[k].dm) << SH;

        always_comb begin
            n_d = r_dv[k];
            if (r_dv[k].remx >= dsh) begin
                n_d.remx     = r_dv[k].remx - dsh;
                n_d.qx[SH]   = 1'b1;
            end
            if (r_dv[k].remy >= dsh) begin
                n_d.remy     = r_dv[k].remy - dsh;
                n_d.qy[SH]   = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k+1] <= 1'b0;
            end else if (en) begin
                r_dvld[k+1] <= r_dvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k+1] <= n_d;
            end
        end
    end

    // ---------------- output stage: sign, saturate, box test
    t_div                      fin;
    logic signed [COORD_W-1:0] n_px, n_py;
    logic                      n_inx, n_iny, n_hit;

    assign fin = r_dv[Q_W];

    always_comb begin
        // x quotient
        if (fin.negx) begin
            if (fin.ovfx || (fin.qx[Q_W-1] && (fin.qx[Q_W-2:0] != '0))) begin
                n_px = COORD_MIN;
            end else begin
                n_px = $signed(COORD_W'(-fin.qx));
            end
        end else begin
            if (fin.ovfx || fin.qx[Q_W-1]) begin
                n_px = COORD_MAX;
            end else begin
                n_px = $signed(fin.qx);
            end
        end
        // y quotient
        if (fin.negy) begin
            if (fin.ovfy || (fin.qy[Q_W-1] && (fin.qy[Q_W-2:0] != '0))) begin
                n_py = COORD_MIN;
            end else begin
                n_py = $signed(COORD_W'(-fin.qy));
            end
        end else begin
            if (fin.ovfy || fin.qy[Q_W-1]) begin
                n_py = COORD_MAX;
            end else begin
                n_py = $signed(fin.qy);
            end
        end
        n_inx = (fin.box.xlo < BND_W'(n_px)) && (BND_W'(n_px) < fin.box.xhi);
        n_iny = (fin.box.ylo < BND_W'(n_py)) && (BND_W'(n_py) < fin.box.yhi);
        if (fin.box.nv) begin
            n_hit = n_iny;
        end else if (fin.box.nh) begin
            n_hit = n_inx;
        end else begin
            n_hit = n_inx && n_iny;
        end
    end

    logic                      r_out_cross, r_out_par;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dvld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (fin.box.par) begin
                r_out_cross <= 1'b0;
                r_out_par   <= 1'b1;
                r_out_x     <= '0;
                r_out_y     <= '0;
            end else begin
                r_out_cross <= n_hit;
                r_out_par   <= 1'b0;
                r_out_x     <= n_px;
                r_out_y     <= n_py;
            end
        end
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.crosses     = r_out_cross;
    assign o_result.is_parallel = r_out_par;
    assign o_result.meet_x      = r_out_x;
    assign o_result.meet_y      = r_out_y;

endmodule

`default_nettype wire
